/* rtl/core/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded double-ended queue with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_SEARCH     = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               found;
		logic [3:0]         position;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} bdq_res_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_SRCH = 4'b0100,
		S_DONE = 4'b1000
	} bdq_state_t;

endpackage

/* rtl/core/bdq_req_if.sv */
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: operation mode and operand value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] value_in;

	modport source (output valid, output mode, output value_in, input ready);
	modport sink (input valid, input mode, input value_in, output ready);
endinterface

/* rtl/core/bdq_rsp_if.sv */
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Result channel: popped value, search outcome, status and occupancy.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_out;
	logic               found;
	logic [3:0]         position;
	logic [1:0]         status;
	logic [4:0]         occupancy;

	modport source (output valid, output value_out, output found, output position,
		output status, output occupancy, input ready);
	modport sink (input valid, input value_out, input found, input position,
		input status, input occupancy, output ready);
endinterface

/* rtl/core/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic signed [31:0]         wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic signed [31:0]         rdata
);
	logic signed [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* rtl/core/bounded_deque_with_search_core.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Double-ended queue of signed 32-bit values in a ring store, with search.
// ----------------------------------------------------------------------------
// One request at a time. A push goes from acceptance to S_DONE, a pop
// through S_RD to capture the read data, and a search runs in S_SRCH
// until a hit or the last compare (an empty deque is not scanned): the
// single read port of the entry store is walked one entry per cycle from
// the front, with the equality compare on the registered read data in the
// cycle after the read. A request is taken while an earlier result still
// waits on the output register; the new result is loaded once that one has
// gone. Out-of-range modes return zeros with the current occupancy. For
// DEPTH above 16 position and occupancy carry their low 4 and 5 bits only.
module bounded_deque_with_search_core #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bdq_req_if.sink     req,
	bdq_rsp_if.source   rsp
);
	import bdq_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bdq_state_t         state_q;
	logic [IW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      scan_q;
	logic               cmp_v_q;
	logic [IW-1:0]      cmp_off_q;
	logic signed [31:0] key_q;
	bdq_res_t           res_q;
	bdq_res_t           out_q;
	logic               out_v_q;

	logic               accept;
	logic               full;
	logic               empty;
	logic [CW-1:0]      cnt_m1;
	logic [IW-1:0]      off_sel;
	logic [IW:0]        sum;
	logic [IW-1:0]      slot;
	logic [IW-1:0]      front_dec;
	logic [IW-1:0]      front_inc;
	logic               scan_more;
	logic               hit;
	logic               last_cmp;
	logic               we;
	logic [IW-1:0]      waddr;
	logic               re;
	logic signed [31:0] rdata;
	logic [IW+3:0]      pos_ext;
	logic [CW+4:0]      occ_ext;
	logic               out_free;
	logic [1:0]         acc_status;
	bdq_res_t           res_fin;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign cnt_m1    = count_q - 1'b1;
	assign scan_more = (scan_q < count_q);
	assign out_free  = !out_v_q || rsp.ready;

	// shared ring address unit: front + offset, wrapped at DEPTH
	always_comb begin
		off_sel = '0;
		if (state_q == S_SRCH) begin
			off_sel = scan_q[IW-1:0];
		end else if (req.mode == MODE_PUSH_BACK) begin
			off_sel = count_q[IW-1:0];
		end else if (req.mode == MODE_POP_BACK) begin
			off_sel = cnt_m1[IW-1:0];
		end
	end

	assign sum  = {1'b0, front_q} + {1'b0, off_sel};
	assign slot = (sum >= DEPTH_W) ? IW'(sum - DEPTH_W) : sum[IW-1:0];

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;

	assign we    = accept && !full
		&& (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_BACK);
	assign waddr = (req.mode == MODE_PUSH_FRONT) ? front_dec : slot;
	assign re    = (accept && !empty
		&& (req.mode == MODE_POP_FRONT || req.mode == MODE_POP_BACK))
		|| (state_q == S_SRCH && scan_more);

	bdq_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req.value_in),
		.re    (re),
		.raddr (slot),
		.rdata (rdata)
	);

	assign hit      = cmp_v_q && (rdata == key_q);
	assign last_cmp = cmp_v_q && (cmp_off_q == cnt_m1[IW-1:0]);
	assign pos_ext  = {4'b0, cmp_off_q};
	assign occ_ext  = {5'b0, count_q};

	always_comb begin
		acc_status = STATUS_OK;
		if (full && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_BACK)) begin
			acc_status = STATUS_FULL;
		end else if (empty && (req.mode == MODE_POP_FRONT || req.mode == MODE_POP_BACK)) begin
			acc_status = STATUS_EMPTY;
		end
	end

	always_comb begin
		res_fin           = res_q;
		res_fin.occupancy = occ_ext[4:0];
	end

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			scan_q  <= '0;
			cmp_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						unique case (req.mode)
							MODE_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_dec;
									count_q <= count_q + 1'b1;
								end
							end
							MODE_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							MODE_POP_FRONT: begin
								if (!empty) begin
									front_q <= front_inc;
									count_q <= cnt_m1;
									state_q <= S_RD;
								end
							end
							MODE_POP_BACK: begin
								if (!empty) begin
									count_q <= cnt_m1;
									state_q <= S_RD;
								end
							end
							MODE_SEARCH: begin
								if (!empty) begin
									scan_q  <= '0;
									cmp_v_q <= 1'b0;
									state_q <= S_SRCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_DONE;
				end
				S_SRCH: begin
					if (scan_more) begin
						scan_q  <= scan_q + 1'b1;
						cmp_v_q <= 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
					end
					if (hit || last_cmp) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q           <= req.value_in;
			res_q.value_out <= '0;
			res_q.found     <= 1'b0;
			res_q.position  <= '0;
			res_q.status    <= acc_status;
			res_q.occupancy <= '0;
		end
		if (state_q == S_RD) begin
			res_q.value_out <= rdata;
		end
		if (state_q == S_SRCH) begin
			if (scan_more) begin
				cmp_off_q <= scan_q[IW-1:0];
			end
			if (hit) begin
				res_q.found    <= 1'b1;
				res_q.position <= pos_ext[3:0];
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_fin;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.value_out = out_q.value_out;
	assign rsp.found     = out_q.found;
	assign rsp.position  = out_q.position;
	assign rsp.status    = out_q.status;
	assign rsp.occupancy = out_q.occupancy;
endmodule

/* rtl/core/bdq_chk.sv */
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks on the result channel, bound to the queue core.
// ----------------------------------------------------------------------------
module bdq_chk #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] value_out,
	input logic        found,
	input logic [3:0]  position,
	input logic [1:0]  status,
	input logic [4:0]  occupancy
);
	import bdq_pkg::*;

	// a search hit never carries an error or a popped value
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> status == STATUS_OK && value_out == '0)
		else $error("search hit with status or value set");

	// failed requests return no data
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STATUS_OK |-> !found && position == '0 && value_out == '0)
		else $error("failed request returned data");

	a_pos_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> position == '0)
		else $error("position without a hit");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && DEPTH <= 16 |-> occupancy <= 5'(DEPTH))
		else $error("occupancy above depth");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(value_out) && $stable(found)
			&& $stable(position) && $stable(status) && $stable(occupancy))
		else $error("result changed while stalled");
endmodule

bind bounded_deque_with_search_core bdq_chk #(.DEPTH(DEPTH)) u_bdq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.value_out (rsp.value_out),
	.found     (rsp.found),
	.position  (rsp.position),
	.status    (rsp.status),
	.occupancy (rsp.occupancy)
);

/* sim/bounded_deque_with_search_core_test.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core_test
// Requests go in as a short directed table and then as random traffic biased
// towards filling or draining the deque. A behavioural deque with its own
// store, head and count predicts each result that the table does not fix.
// Results are checked in order, field by field, with random stalls on both
// channels and a long output hold-off.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int unsigned STORE_DEPTH   = 16;
	localparam int unsigned RANDOM_ITEMS  = 1050;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned REPORT_MAX    = 10;

	// modes outside the defined set
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
		logic [4:0]         reps;
		logic               typed;
		bdq_res_t           result;
	} stim_row_t;

	localparam stim_row_t DIRECTED_PLAN [15] = '{
		'{MODE_POP_FRONT, 32'sd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_EMPTY, 5'd0}},
		'{MODE_POP_BACK, 32'sd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_EMPTY, 5'd0}},
		'{MODE_SEARCH, 32'sd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_OK, 5'd0}},
		'{MODE_UNUSED_LO, 32'sd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_OK, 5'd0}},
		'{MODE_PUSH_BACK, 32'h7FFF_FFFF, 5'd1, 1'b1,
			'{32'sd0, 1'b0, 4'd0, STATUS_OK, 5'd1}},
		'{MODE_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1,
			'{32'sd0, 1'b0, 4'd0, STATUS_OK, 5'd2}},
		'{MODE_POP_FRONT, 32'sd0, 5'd1, 1'b1,
			'{32'h8000_0000, 1'b0, 4'd0, STATUS_OK, 5'd1}},
		'{MODE_POP_BACK, 32'sd0, 5'd1, 1'b1,
			'{32'h7FFF_FFFF, 1'b0, 4'd0, STATUS_OK, 5'd0}},
		// fill with -1, 0, 1 ... then a front push wraps the head below slot 0
		'{MODE_PUSH_BACK, -32'sd1, 5'd15, 1'b0, '0},
		'{MODE_PUSH_FRONT, 32'sd0, 5'd1, 1'b0, '0},
		'{MODE_PUSH_FRONT, 32'sd9, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_FULL, 5'd16}},
		'{MODE_PUSH_BACK, 32'sd9, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_FULL, 5'd16}},
		'{MODE_SEARCH, 32'sd5, 5'd1, 1'b0, '0},
		// duplicate value: first match wins
		'{MODE_SEARCH, 32'sd0, 5'd1, 1'b0, '0},
		'{MODE_UNUSED_HI, 32'sd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, STATUS_OK, 5'd16}}
	};

	logic clk;
	logic arst_n;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_search_core #(
		.DEPTH(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// behavioural deque
	logic signed [31:0] deque_store [STORE_DEPTH];
	logic [3:0]         head_slot;
	logic [4:0]         held_count;

	bdq_res_t pending_results [$];
	int unsigned failure_count;
	bit calm_phase;
	bit hold_off_go;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bdq_res_t deque_apply(input logic [2:0] m, input logic signed [31:0] v);
		bdq_res_t res;
		logic [3:0] slot;
		res = '0;
		case (m)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (held_count == 5'(STORE_DEPTH)) begin
					res.status = STATUS_FULL;
				end else if (m == MODE_PUSH_FRONT) begin
					head_slot = head_slot - 4'd1;
					deque_store[head_slot] = v;
					held_count = held_count + 5'd1;
				end else begin
					deque_store[head_slot + held_count[3:0]] = v;
					held_count = held_count + 5'd1;
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (held_count == 5'd0) begin
					res.status = STATUS_EMPTY;
				end else if (m == MODE_POP_FRONT) begin
					res.value_out = deque_store[head_slot];
					head_slot = head_slot + 4'd1;
					held_count = held_count - 5'd1;
				end else begin
					slot = head_slot + held_count[3:0] - 4'd1;
					res.value_out = deque_store[slot];
					held_count = held_count - 5'd1;
				end
			end
			MODE_SEARCH: begin
				for (int i = 0; i < int'(held_count); i++) begin
					slot = head_slot + 4'(i);
					if (!res.found && deque_store[slot] == v) begin
						res.found = 1'b1;
						res.position = 4'(i);
					end
				end
			end
			default: ;
		endcase
		res.occupancy = held_count;
		return res;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input logic [2:0] m, input logic signed [31:0] v,
		input logic typed, input bdq_res_t fixed);
		bdq_res_t predicted;
		while (!calm_phase && $urandom_range(0, 99) < 19) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.value_in <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = deque_apply(m, v);
		pending_results.push_back(typed ? fixed : predicted);
		@(negedge clk);
	endtask

	// random request; among pushes and pops, push_bias percent are pushes
	task automatic send_random(input int unsigned push_bias);
		logic [2:0] m;
		logic signed [31:0] v;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 40) begin
			case ($urandom_range(0, 4))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = -32'sd1;
				default: v = 32'($urandom_range(0, 7));
			endcase
		end else begin
			v = $urandom;
		end
		if (pick < 3) begin
			m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		end else if (pick < 18) begin
			m = MODE_SEARCH;
			if (held_count != 5'd0 && $urandom_range(0, 99) < 70)
				v = deque_store[head_slot + 4'($urandom_range(0, held_count - 1))];
		end else if ($urandom_range(0, 99) < push_bias) begin
			m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
		end else begin
			m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
		end
		send_request(m, v, 1'b0, '0);
	endtask

	initial begin
		int unsigned push_bias;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_PUSH_FRONT;
		req_ch.value_in = '0;
		arst_n = 1'b0;
		head_slot = '0;
		held_count = '0;
		failure_count = 0;
		calm_phase = 1'b0;
		hold_off_go = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++) deque_store[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_PLAN[r]) begin
			for (int k = 0; k < int'(DIRECTED_PLAN[r].reps); k++)
				send_request(DIRECTED_PLAN[r].mode, DIRECTED_PLAN[r].value + 32'(k),
					DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].result);
		end

		push_bias = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: push_bias = 90;
					1: push_bias = 10;
					default: push_bias = 50;
				endcase
			end
			calm_phase = (n >= 300 && n < 500);
			if (n == 600) hold_off_go = 1'b1;
			if (n == 800) begin
				// let every outstanding request drain before carrying on
				req_ch.valid <= 1'b0;
				@(negedge clk);
				while (pending_results.size() != 0) @(negedge clk);
			end
			send_random(push_bias);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failure_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// result side: random back-pressure plus one long hold-off
	initial begin
		bit hold_off_done;
		hold_off_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go && !hold_off_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
			end else begin
				rsp_ch.ready <= calm_phase || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	always @(posedge clk) begin
		bdq_res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				failure_count++;
				if (failure_count <= REPORT_MAX)
					$display("unexpected result: value=%0d occ=%0d", rsp_ch.value_out,
						rsp_ch.occupancy);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.value_out !== want.value_out || rsp_ch.found !== want.found ||
					rsp_ch.position !== want.position || rsp_ch.status !== want.status ||
					rsp_ch.occupancy !== want.occupancy) begin
					failure_count++;
					if (failure_count <= REPORT_MAX)
						$display("mismatch: exp val=%0d fnd=%0b pos=%0d st=%0d occ=%0d, got val=%0d fnd=%0b pos=%0d st=%0d occ=%0d",
							want.value_out, want.found, want.position, want.status,
							want.occupancy, rsp_ch.value_out, rsp_ch.found, rsp_ch.position,
							rsp_ch.status, rsp_ch.occupancy);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/bdq_pkg.sv
rtl/core/bdq_req_if.sv
rtl/core/bdq_rsp_if.sv
rtl/core/bdq_ram.sv
rtl/core/bounded_deque_with_search_core.sv
rtl/core/bdq_chk.sv
sim/bounded_deque_with_search_core_test.sv
